FILE: rtl/bdeq_pkg.sv
// shared types and constants of the bounded double-ended queue
package bdeq_pkg;

	localparam int DATA_W       = 32;
	localparam int OPC_W        = 3;
	localparam int STS_W        = 2;
	localparam int CAPACITY_DEF = 32;
	localparam int S_TDATA_W    = 40;
	localparam int M_TDATA_W    = 40;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST       = 3'd4
	} opcode_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    latch;       // capture the incoming request
		logic    push;        // write the word, move pointers
		logic    pop;         // read the end slot, move pointers
		logic    list_start;  // read the front slot
		logic    list_step;   // read the next slot of the walk
		logic    load;        // load the output register
		status_t status;
		logic    with_data;   // word comes from the store read port
		logic    last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OPC_W-1:0] op;
		logic             full;
		logic             empty;
		logic             list_last;
		logic             out_free;
	} sts_t;

endpackage

FILE: rtl/bdeq_ram.sv
// generic single write port, single registered read port ram
module bdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/bdeq_dp.sv
// datapath: request latch, ring pointers, element store and output register
module bdeq_dp #(
	parameter int CAPACITY = bdeq_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bdeq_pkg::OPC_W-1:0]   opcode,
	input  logic [bdeq_pkg::DATA_W-1:0]  value,
	input  bdeq_pkg::cmd_t               cmd,
	output bdeq_pkg::sts_t               sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bdeq_pkg::STS_W-1:0]   out_status,
	output logic [bdeq_pkg::DATA_W-1:0]  out_word,
	output logic                         out_last
);

	import bdeq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
	localparam logic [IW:0]   CAP_W     = (IW + 1)'(CAPACITY);

	logic [OPC_W-1:0]  req_op_q;
	logic [DATA_W-1:0] req_val_q;
	logic [IW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     list_off_q;
	logic              out_valid_q;
	logic [STS_W-1:0]  out_status_q;
	logic [DATA_W-1:0] out_word_q;
	logic              out_last_q;

	logic [IW-1:0]     front_inc;
	logic [IW-1:0]     front_dec;
	logic [IW-1:0]     back_wr;
	logic [IW-1:0]     back_rd;
	logic [IW-1:0]     next_off;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	// ring slot at an offset from a base, offset below capacity
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[IW-1:0];
	endfunction

	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
	assign back_wr   = slot(front_q, count_q[IW-1:0]);
	assign back_rd   = slot(front_q, count_q[IW-1:0] - 1'b1);
	assign next_off  = list_off_q + 1'b1;

	assign wr_en   = cmd.push;
	assign wr_addr = (req_op_q == OP_PUSH_FRONT) ? front_dec : back_wr;

	assign rd_en = cmd.pop || cmd.list_start || cmd.list_step;

	always_comb begin
		if (cmd.list_step) begin
			rd_addr = slot(front_q, next_off);
		end else if (cmd.pop && req_op_q == OP_POP_BACK) begin
			rd_addr = back_rd;
		end else begin
			rd_addr = front_q;
		end
	end

	bdeq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req_val_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_op_q  <= opcode;
			req_val_q <= value;
		end
		if (cmd.list_start) begin
			list_off_q <= '0;
		end else if (cmd.list_step) begin
			list_off_q <= next_off;
		end
		if (cmd.load) begin
			out_status_q <= cmd.status;
			out_word_q   <= cmd.with_data ? rd_data : '0;
			out_last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
				if (req_op_q == OP_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
				if (req_op_q == OP_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op        = req_op_q;
	assign sts.full      = (count_q == CW'(CAPACITY));
	assign sts.empty     = (count_q == '0);
	assign sts.list_last = ((CW'(list_off_q) + CW'(1)) == count_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_word   = out_word_q;
	assign out_last   = out_last_q;

endmodule

FILE: rtl/bdeq_ctrl.sv
// controller state machine sequencing one request at a time
module bdeq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bdeq_pkg::sts_t sts,
	output bdeq_pkg::cmd_t cmd
);

	import bdeq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_LIST = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.status     = STS_OK;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op) inside
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (sts.out_free) begin
							cmd.load   = 1'b1;
							cmd.last   = 1'b1;
							cmd.push   = !sts.full;
							cmd.status = sts.full ? STS_FULL : STS_OK;
							state_d    = S_IDLE;
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.load   = 1'b1;
								cmd.last   = 1'b1;
								cmd.status = STS_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.pop = 1'b1;
							state_d = S_POP;
						end
					end
					OP_LIST: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.load   = 1'b1;
								cmd.last   = 1'b1;
								cmd.status = STS_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.list_start = 1'b1;
							state_d        = S_LIST;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.load      = 1'b1;
					cmd.with_data = 1'b1;
					cmd.last      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.load      = 1'b1;
					cmd.with_data = 1'b1;
					cmd.last      = sts.list_last;
					cmd.list_step = !sts.list_last;
					if (sts.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/bounded_double_ended_queue.sv
// top level of the bounded double-ended queue of signed 32-bit words
//
// usage
// - slave channel (s_*) takes one request per handshake: push front, push
//   back, pop front, pop back or list; any other opcode is dropped silently
// - master channel (m_*) returns results; m_tlast marks the final result of
//   a request, and every push or pop yields exactly one result
// - a list request streams the held words front to back, one per cycle while
//   m_tready stays high, or one empty-status result when nothing is held
// - the controller latches a request in idle and acts on it in exec; a pop
//   or a list starts its read of the element store there, and the word then
//   leaves from the pop or list state behind the registered read port, while
//   a push result or an empty status is loaded into the output register in exec
// - one request is worked on at a time; s_tready rises again once the last
//   result of the previous request sits in the output register
// - when the receiver stalls, the output register holds its result and the
//   controller waits with the next one; nothing is dropped
// - reset empties the queue (front pointer and count cleared); the store
//   contents are left undefined, and no clearing pass is needed
module bounded_double_ended_queue #(
	parameter int CAPACITY = bdeq_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bdeq_pkg::S_TDATA_W-1:0] s_tdata,  // opcode[2:0], value[34:3], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bdeq_pkg::M_TDATA_W-1:0] m_tdata,  // status[1:0], word[33:2], zero pad
	output logic                          m_tlast
);

	import bdeq_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [OPC_W-1:0]  opcode;
	logic [DATA_W-1:0] value;
	logic [STS_W-1:0]  status;
	logic [DATA_W-1:0] word;

	// request unpacking
	assign opcode = s_tdata[OPC_W-1:0];
	assign value  = s_tdata[OPC_W +: DATA_W];

	bdeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdeq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_word   (word),
		.out_last   (m_tlast)
	);

	// result packing, status in the low bits
	assign m_tdata = {{(M_TDATA_W - STS_W - DATA_W){1'b0}}, word, status};

`ifndef SYNTHESIS
	// a push never writes into a full store
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> !sts.full)
		else $error("push issued while queue full");

	// pops and list walks only start on a non-empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop || cmd.list_start) |-> !sts.empty)
		else $error("store read started on empty queue");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> sts.out_free)
		else $error("output register overwritten");

	// the list walk stops at the last held element
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.list_step |-> !sts.list_last)
		else $error("list walk ran past the back");
`endif

endmodule
